// ----- rtl/bpa_pkg.sv -----
package bpa_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_FIN
  } st_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_NEW   = 3'd1;
  localparam status_t ST_LARGE = 3'd2;
  localparam status_t ST_FULL  = 3'd3;
  localparam status_t ST_BAD   = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic vld;
    logic hit;
  } fit_stat_t;

endpackage

// ----- rtl/bpa_mem.sv -----
module bpa_mem #(
  parameter int W     = 64,
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/bpa_fit.sv -----
module bpa_fit #(
  parameter int PAGES_PER_CHUNK = 64,
  parameter int PGW             = 6,
  parameter int IW              = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [IW-1:0]              in_idx,
  input  logic [PAGES_PER_CHUNK-1:0] in_mask,
  input  logic [PAGES_PER_CHUNK-1:0] run,
  input  logic [PGW-1:0]             pages,
  output bpa_pkg::fit_stat_t         stat,
  output logic [IW-1:0]              idx,
  output logic [PGW-1:0]             pos,
  output logic [PAGES_PER_CHUNK-1:0] mask
);

  import bpa_pkg::*;

  logic [PAGES_PER_CHUNK-1:0] fit_c;
  logic [PAGES_PER_CHUNK-1:0] fit_r;
  logic [PAGES_PER_CHUNK-1:0] mask_r;
  logic [IW-1:0]              idx_r;
  logic                       vld_r;
  logic [PGW-1:0]             pos_c;

  // window at page g is free and ends inside the chunk
  for (genvar g = 0; g < PAGES_PER_CHUNK; g++) begin : g_win
    assign fit_c[g] = ((in_mask & (run << g)) == '0) &&
                      (((PGW+1)'(pages) + (PGW+1)'(g)) <= (PGW+1)'(PAGES_PER_CHUNK));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    fit_r  <= fit_c;
    mask_r <= in_mask;
    idx_r  <= in_idx;
  end

  always_comb begin
    pos_c = '0;
    for (int k = PAGES_PER_CHUNK - 1; k >= 0; k--) begin
      if (fit_r[k]) begin
        pos_c = PGW'(k);
      end
    end
  end

  assign stat.vld = vld_r;
  assign stat.hit = |fit_r;
  assign idx      = idx_r;
  assign pos      = pos_c;
  assign mask     = mask_r;

endmodule

// ----- rtl/bitmap_page_allocator_core.sv -----
// Bitmap first-fit page allocator, three buffer pools.
// Input channel (in_*): one request per handshake, cmd 0 allocates pages,
// cmd 1 frees them. Result channel (out_*): exactly one result per request,
// in request order. A request is taken when valid is high and stall is low.
// Bad or large requests skip the mask memory; a free reads and rewrites one
// chunk mask; an allocation scans the pool, which holds up to 16 chunks.
// The allocation time is set by the busy-mask memory port: the pool's
// chunk masks are read one per cycle and checked through a registered fit
// unit; the first chunk with room ends the scan.
// One request is processed at a time; in_stall is high from acceptance
// until its result is loaded into the output register. A new request is
// taken while an earlier result still waits on out_stall; its result then
// waits in the block until the output register frees.
// Reset clears the chunk counts and the output valid; the mask memory is
// not cleared, as only masks of appended chunks are ever read.
// PAGE_BYTES must be a power of two.
module bitmap_page_allocator_core #(
  parameter int PAGE_BYTES      = 1024,
  parameter int PAGES_PER_CHUNK = 64,
  parameter int MAX_CHUNKS      = 16,
  parameter int NUM_TYPES       = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_size,
  input  logic [1:0]  in_buffer_type,
  input  logic [3:0]  in_free_chunk,
  input  logic [15:0] in_free_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_chunk_index,
  output logic [15:0] out_byte_offset
);

  import bpa_pkg::*;

  localparam int PPC   = PAGES_PER_CHUNK;
  localparam int CW    = $clog2(MAX_CHUNKS + 1);
  localparam int IW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int DEPTH = NUM_TYPES * MAX_CHUNKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int PGW   = $clog2(PAGES_PER_CHUNK);
  localparam int PB_SH = $clog2(PAGE_BYTES);
  localparam logic [31:0] LIMIT = 32'(PAGE_BYTES * (PAGES_PER_CHUNK - 1));

  st_t           state_r, state_nxt;
  logic [CW-1:0] cnt_r [NUM_TYPES];
  logic [CW-1:0] cnt_nxt [NUM_TYPES];

  logic [TW-1:0]  tidx_r, tidx_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]  cnt_sel_r, cnt_sel_nxt;
  logic [PGW-1:0] pages_r, pages_nxt;
  logic [PPC-1:0] run_r, run_nxt;
  logic [CW-1:0]  issue_r, issue_nxt;
  logic           rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [3:0]     fchunk_r, fchunk_nxt;
  logic [15:0]    foff_r, foff_nxt;
  logic [PGW-1:0] sh_r, sh_nxt;
  logic           sh_ok_r, sh_ok_nxt;
  status_t        res_status_r, res_status_nxt;
  logic [3:0]     res_chunk_r, res_chunk_nxt;
  logic [15:0]    res_off_r, res_off_nxt;
  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [3:0]     out_chunk_r, out_chunk_nxt;
  logic [15:0]    out_off_r, out_off_nxt;

  // request decode
  logic [7:0]     type8;
  logic           type_ok;
  logic [TW-1:0]  tidx_in;
  logic [CW-1:0]  cnt_in;
  logic [32:0]    size_rnd;
  logic [PGW-1:0] pages_in;
  logic [PPC-1:0] run_in;
  logic [8:0]     fchunk9;
  logic           fchunk_ok;
  logic [AW-1:0]  base_in;
  logic [15:0]    sh16;

  // memory and fit unit
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [PPC-1:0] wr_data, rd_data;
  fit_stat_t      fstat;
  logic [IW-1:0]  fit_idx;
  logic [PGW-1:0] fit_pos;
  logic [PPC-1:0] fit_mask;

  assign type8    = {6'b0, in_buffer_type};
  assign type_ok  = type8 < 8'(NUM_TYPES);
  assign tidx_in  = type8[TW-1:0];
  assign cnt_in   = cnt_r[tidx_in];
  assign size_rnd = {1'b0, in_size} + 33'(PAGE_BYTES - 1);
  assign pages_in = size_rnd[PB_SH +: PGW];
  assign fchunk9  = 9'(in_free_chunk);
  assign fchunk_ok = fchunk9 < 9'(cnt_in);
  assign base_in  = AW'(32'(tidx_in) * MAX_CHUNKS);
  assign sh16     = in_free_offset >> PB_SH;

  for (genvar k = 0; k < PPC; k++) begin : g_run
    assign run_in[k] = PGW'(k) < pages_in;
  end

  bpa_mem #(
    .W     (PPC),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bpa_fit #(
    .PAGES_PER_CHUNK (PPC),
    .PGW             (PGW),
    .IW              (IW)
  ) u_fit (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .in_idx  (rd_idx_r),
    .in_mask (rd_data),
    .run     (run_r),
    .pages   (pages_r),
    .stat    (fstat),
    .idx     (fit_idx),
    .pos     (fit_pos),
    .mask    (fit_mask)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    tidx_nxt       = tidx_r;
    base_nxt       = base_r;
    addr_nxt       = addr_r;
    cnt_sel_nxt    = cnt_sel_r;
    pages_nxt      = pages_r;
    run_nxt        = run_r;
    issue_nxt      = issue_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    fchunk_nxt     = fchunk_r;
    foff_nxt       = foff_r;
    sh_nxt         = sh_r;
    sh_ok_nxt      = sh_ok_r;
    res_status_nxt = res_status_r;
    res_chunk_nxt  = res_chunk_r;
    res_off_nxt    = res_off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_chunk_nxt  = out_chunk_r;
    out_off_nxt    = out_off_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    in_stall       = 1'b1;

    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        tidx_nxt    = tidx_in;
        base_nxt    = base_in;
        addr_nxt    = base_in + AW'(fchunk9);
        cnt_sel_nxt = cnt_in;
        pages_nxt   = pages_in;
        run_nxt     = run_in;
        issue_nxt   = '0;
        fchunk_nxt  = in_free_chunk;
        foff_nxt    = in_free_offset;
        sh_nxt      = sh16[PGW-1:0];
        sh_ok_nxt   = sh16 < 16'(PPC);
        res_chunk_nxt = '0;
        res_off_nxt   = '0;
        if (in_valid) begin
          if (in_size == '0 || !type_ok) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_FIN;
          end else if (in_size >= LIMIT) begin
            res_status_nxt = ST_LARGE;
            state_nxt      = S_FIN;
          end else if (in_cmd == CMD_FREE) begin
            if (!fchunk_ok) begin
              res_status_nxt = ST_BAD;
              state_nxt      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = base_in + AW'(fchunk9);
              state_nxt = S_FREE;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (fstat.vld && fstat.hit) begin
          wr_en          = 1'b1;
          wr_addr        = base_r + AW'(fit_idx);
          wr_data        = fit_mask | (run_r << fit_pos);
          res_status_nxt = ST_OK;
          res_chunk_nxt  = 4'(fit_idx);
          res_off_nxt    = 16'(32'(fit_pos) << PB_SH);
          state_nxt      = S_FIN;
        end else if (issue_r != cnt_sel_r) begin
          rd_en      = 1'b1;
          rd_addr    = base_r + AW'(issue_r[IW-1:0]);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[IW-1:0];
          issue_nxt  = issue_r + 1'b1;
        end else if (!rd_vld_r) begin
          if (cnt_sel_r >= CW'(MAX_CHUNKS)) begin
            res_status_nxt = ST_FULL;
          end else begin
            wr_en            = 1'b1;
            wr_addr          = base_r + AW'(cnt_sel_r[IW-1:0]);
            wr_data          = run_r;
            cnt_nxt[tidx_r]  = cnt_sel_r + 1'b1;
            res_status_nxt   = ST_NEW;
            res_chunk_nxt    = 4'(cnt_sel_r);
          end
          state_nxt = S_FIN;
        end
      end
      S_FREE: begin
        wr_en          = sh_ok_r;
        wr_addr        = addr_r;
        wr_data        = rd_data & ~(run_r << sh_r);
        res_status_nxt = ST_OK;
        res_chunk_nxt  = fchunk_r;
        res_off_nxt    = foff_r;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_chunk_nxt  = res_chunk_r;
          out_off_nxt    = res_off_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        cnt_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tidx_r       <= tidx_nxt;
    base_r       <= base_nxt;
    addr_r       <= addr_nxt;
    cnt_sel_r    <= cnt_sel_nxt;
    pages_r      <= pages_nxt;
    run_r        <= run_nxt;
    issue_r      <= issue_nxt;
    rd_idx_r     <= rd_idx_nxt;
    fchunk_r     <= fchunk_nxt;
    foff_r       <= foff_nxt;
    sh_r         <= sh_nxt;
    sh_ok_r      <= sh_ok_nxt;
    res_status_r <= res_status_nxt;
    res_chunk_r  <= res_chunk_nxt;
    res_off_r    <= res_off_nxt;
    out_status_r <= out_status_nxt;
    out_chunk_r  <= out_chunk_nxt;
    out_off_r    <= out_off_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chunk_index = out_chunk_r;
  assign out_byte_offset = out_off_r;

endmodule

// ----- rtl/bpa_chk.sv -----
module bpa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_cmd,
  input logic [31:0] in_size,
  input logic [1:0]  in_buffer_type,
  input logic [3:0]  in_free_chunk,
  input logic [15:0] in_free_offset,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [3:0]  out_chunk_index,
  input logic [15:0] out_byte_offset
);

  import bpa_pkg::*;

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_BAD))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_LARGE || out_status == ST_FULL ||
                  out_status == ST_BAD)
    |-> (out_chunk_index == 4'd0) && (out_byte_offset == 16'd0))
    else $error("failed request carries a location");

  a_new_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NEW |-> out_byte_offset == 16'd0)
    else $error("new chunk result has nonzero offset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_chunk_index) && $stable(out_byte_offset))
    else $error("stalled result changed");

endmodule

bind bitmap_page_allocator_core bpa_chk u_bpa_chk (.*);
